>>> design/footprint_relation_cut_finder_macros.svh
// Assertion macros for the footprint relation cut finder checker.
`ifndef FOOTPRINT_RELATION_CUT_FINDER_MACROS_SVH
`define FOOTPRINT_RELATION_CUT_FINDER_MACROS_SVH

// Same-cycle implication, off during reset.
`define FRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define FRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/frc_pkg.sv
// Shared constants and controller/datapath interface types for the cut finder.
package frc_pkg;

    localparam int EVENT_CAP = 16;
    localparam int MASK_W    = 16;
    localparam int IDX_W     = 4;
    localparam int KIND_W    = 2;
    localparam int CFG_W     = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CONN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAR  = 2'd2;

    typedef struct packed {
        logic add;
        logic start;
        logic seed;
        logic expand;
        logic close;
        logic rd;
        logic emit;
        logic fail;
    } t_dp_cmd;

    typedef struct packed {
        logic all_visited;
        logic pend_empty;
        logic comp_bad;
        logic emit_last;
        logic out_free;
    } t_dp_sts;

endpackage

>>> design/footprint_relation_cut_finder.sv
// Top level of the footprint relation cut finder: controller plus datapath.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------------
//  config   | in        | i_cfg_we               | i_cfg_wdata (active_events)
//  item in  | in        | i_in_valid / o_in_stall | i_kind i_from_event i_to_event masks
//  item out | out       | o_out_valid / i_out_stall | o_component_mask o_is_last o_failed
//
// Add items may follow every cycle and do not raise the input stall.
// A query walks one event per cycle, one component after another (seed, expand, close),
// then reads each result from the component store before emitting it; input stall stays high
// until the last result is loaded into the output register.
// Reset is synchronous and clears the pair matrices.
// The output register holds a result while i_out_stall is high; readout waits behind it.
module footprint_relation_cut_finder import frc_pkg::*; #(
    parameter int MAX_EVENTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [IDX_W-1:0]  i_from_event,
    input  logic [IDX_W-1:0]  i_to_event,
    input  logic [MASK_W-1:0] i_start_mask,
    input  logic [MASK_W-1:0] i_end_mask,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [MASK_W-1:0] o_component_mask,
    output logic              o_is_last,
    output logic              o_failed
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    frc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    frc_dp #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_kind           (i_kind),
        .i_from_event     (i_from_event),
        .i_to_event       (i_to_event),
        .i_start_mask     (i_start_mask),
        .i_end_mask       (i_end_mask),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_component_mask (o_component_mask),
        .o_is_last        (o_is_last),
        .o_failed         (o_failed)
    );

endmodule

>>> design/frc_ctrl.sv
// Controller state machine that sequences pair updates, component walks and result output.
module frc_ctrl import frc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [KIND_W-1:0] i_kind,
    output logic              o_in_stall,
    input  t_dp_sts           i_sts,
    output t_dp_cmd           o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_EXPAND,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_FAIL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind) inside
                        KIND_ADD: begin
                            o_cmd.add = 1'b1;
                        end
                        KIND_CONN, KIND_PAR: begin
                            o_cmd.start = 1'b1;
                            n_state     = ST_SEED;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEED: begin
                if (i_sts.all_visited) begin
                    n_state = ST_EMIT_RD;
                end else begin
                    o_cmd.seed = 1'b1;
                    n_state    = ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                if (!i_sts.pend_empty) begin
                    o_cmd.expand = 1'b1;
                end else if (i_sts.comp_bad) begin
                    n_state = ST_FAIL;
                end else begin
                    o_cmd.close = 1'b1;
                    n_state     = ST_SEED;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_FAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.fail = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/frc_dp.sv
// Datapath with the seen-pair matrices, component walk registers, result store and output stage.
module frc_dp import frc_pkg::*; #(
    parameter int MAX_EVENTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [IDX_W-1:0]  i_from_event,
    input  logic [IDX_W-1:0]  i_to_event,
    input  logic [MASK_W-1:0] i_start_mask,
    input  logic [MASK_W-1:0] i_end_mask,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [MASK_W-1:0] o_component_mask,
    output logic              o_is_last,
    output logic              o_failed
);

    localparam int EV = (MAX_EVENTS < EVENT_CAP) ? MAX_EVENTS : EVENT_CAP;
    localparam int IW = $clog2(EV);
    localparam int CW = IW + 1;

    logic [CFG_W-1:0]  r_active;
    logic [EV-1:0]     r_seen   [EV];
    logic [EV-1:0]     r_seen_t [EV];
    logic [EV-1:0]     r_visited;
    logic [EV-1:0]     r_comp;
    logic [EV-1:0]     r_pend;
    logic [EV-1:0]     r_starts;
    logic [EV-1:0]     r_ends;
    logic              r_par;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_k;
    logic [EV-1:0]     r_found  [EV];
    logic [EV-1:0]     r_rd_data;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_mask;
    logic              r_out_last;
    logic              r_out_failed;

    logic [CFG_W-1:0]  w_n;
    logic [EV-1:0]     w_active;
    logic              w_add_ok;
    logic [IW-1:0]     w_a;
    logic [IW-1:0]     w_b;
    logic [EV-1:0]     w_one;
    logic [EV-1:0]     w_unvis;
    logic [EV-1:0]     w_seed_bit;
    logic [EV-1:0]     w_pick;
    logic [IW-1:0]     w_v;
    logic [EV-1:0]     w_row_s;
    logic [EV-1:0]     w_row_t;
    logic [EV-1:0]     w_link;
    logic [EV-1:0]     w_nb;

    always_comb begin
        if (r_active == '0) begin
            w_n = CFG_W'(1);
        end else if (r_active > CFG_W'(EV)) begin
            w_n = CFG_W'(EV);
        end else begin
            w_n = r_active;
        end
        for (int i = 0; i < EV; i++) begin
            w_active[i] = (CFG_W'(i) < w_n);
        end
    end

    assign w_add_ok = (CFG_W'(i_from_event) < w_n) && (CFG_W'(i_to_event) < w_n);
    assign w_a      = i_from_event[IW-1:0];
    assign w_b      = i_to_event[IW-1:0];

    assign w_one      = {{(EV-1){1'b0}}, 1'b1};
    assign w_unvis    = w_active & ~r_visited;
    assign w_seed_bit = w_unvis & (~w_unvis + w_one);
    assign w_pick     = r_pend & (~r_pend + w_one);

    always_comb begin
        w_v = '0;
        for (int i = 0; i < EV; i++) begin
            if (w_pick[i]) begin
                w_v = w_v | IW'(i);
            end
        end
    end

    assign w_row_s = r_seen[w_v];
    assign w_row_t = r_seen_t[w_v];
    assign w_link  = r_par ? ~(w_row_s & w_row_t) : (w_row_s | w_row_t);
    assign w_nb    = w_link & ~r_comp & ~r_visited & w_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= CFG_RESET;
            for (int i = 0; i < EV; i++) begin
                r_seen[i]   <= '0;
                r_seen_t[i] <= '0;
            end
            r_visited   <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (i_cmd.add && w_add_ok) begin
                r_seen[w_a][w_b]   <= 1'b1;
                r_seen_t[w_b][w_a] <= 1'b1;
            end
            if (i_cmd.start) begin
                r_visited <= '0;
                r_count   <= '0;
                r_k       <= '0;
            end
            if (i_cmd.close) begin
                r_visited <= r_visited | r_comp;
                r_count   <= CW'(r_count + 1'b1);
            end
            if (i_cmd.emit) begin
                r_k <= CW'(r_k + 1'b1);
            end
            if (i_cmd.emit || i_cmd.fail) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_starts <= i_start_mask[EV-1:0];
            r_ends   <= i_end_mask[EV-1:0];
            r_par    <= (i_kind == KIND_PAR);
        end
        if (i_cmd.seed) begin
            r_comp <= w_seed_bit;
            r_pend <= w_seed_bit;
        end
        if (i_cmd.expand) begin
            r_comp <= r_comp | w_nb;
            r_pend <= (r_pend & ~w_pick) | w_nb;
        end
        if (i_cmd.close) begin
            r_found[r_count[IW-1:0]] <= r_comp;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_found[r_k[IW-1:0]];
        end
        if (i_cmd.emit) begin
            r_out_mask   <= MASK_W'(r_rd_data);
            r_out_last   <= o_sts.emit_last;
            r_out_failed <= 1'b0;
        end
        if (i_cmd.fail) begin
            r_out_mask   <= '0;
            r_out_last   <= 1'b1;
            r_out_failed <= 1'b1;
        end
    end

    assign o_sts.all_visited = (r_visited == w_active);
    assign o_sts.pend_empty  = (r_pend == '0);
    assign o_sts.comp_bad    = ((r_comp & r_starts) == '0) || ((r_comp & r_ends) == '0);
    assign o_sts.emit_last   = (CW'(r_k + 1'b1) == r_count);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_component_mask = r_out_mask;
    assign o_is_last        = r_out_last;
    assign o_failed         = r_out_failed;

endmodule

>>> design/frc_chk.sv
// Port-level checker for the cut finder and its bind to the top level.
`include "footprint_relation_cut_finder_macros.svh"

module frc_chk import frc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_stall,
    input logic [KIND_W-1:0] i_kind,
    input logic              i_out_valid,
    input logic              i_out_stall,
    input logic [MASK_W-1:0] i_out_mask,
    input logic              i_out_last,
    input logic              i_out_failed
);

    logic w_take_add;
    logic w_take_qry;

    assign w_take_add = i_in_valid && !i_in_stall && (i_kind == KIND_ADD);
    assign w_take_qry = i_in_valid && !i_in_stall
                        && ((i_kind == KIND_CONN) || (i_kind == KIND_PAR));

    `FRC_ASSERT_NEXT(a_add_keeps_open, i_clk, i_rst_n, w_take_add, !i_in_stall,
                     "add item closed the input")
    `FRC_ASSERT_NEXT(a_query_closes, i_clk, i_rst_n, w_take_qry, i_in_stall,
                     "query item did not stall the input")
    `FRC_ASSERT_NOW(a_fail_shape, i_clk, i_rst_n, i_out_valid && i_out_failed,
                    (i_out_mask == '0) && i_out_last, "failed item has members or is not last")
    `FRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall,
                     i_out_valid && $stable(i_out_mask) && $stable(i_out_last)
                     && $stable(i_out_failed), "stalled output item changed")

endmodule

bind footprint_relation_cut_finder frc_chk u_frc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_stall   (o_in_stall),
    .i_kind       (i_kind),
    .i_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .i_out_mask   (o_component_mask),
    .i_out_last   (o_is_last),
    .i_out_failed (o_failed)
);

>>> sim/tb_top.sv
// Self-checking testbench for the footprint relation cut finder: relation updates and cut queries.
`timescale 1ns / 100ps

module tb_top import frc_pkg::*; ();

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam logic [1:0] REL_NONE     = 2'd0;
    localparam logic [1:0] REL_PRECEDES = 2'd1;
    localparam logic [1:0] REL_FOLLOWS  = 2'd2;
    localparam logic [1:0] REL_PARALLEL = 2'd3;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              is_last;
        logic              failed;
    } t_cut;

    class cut_tracker;
        logic [1:0]       rel [EVENT_CAP][EVENT_CAP];
        logic [CFG_W-1:0] event_count;
        t_cut             expected_cuts[$];
        int               errors;
        int               items_taken;
        int               queries;
        int               results_seen;

        function new();
            foreach (rel[i, j]) rel[i][j] = REL_NONE;
            event_count  = CFG_RESET;
            errors       = 0;
            items_taken  = 0;
            queries      = 0;
            results_seen = 0;
        endfunction

        function int span();
            int n;
            n = int'(event_count);
            if (n < 1) n = 1;
            if (n > EVENT_CAP) n = EVENT_CAP;
            return n;
        endfunction

        function void set_count(logic [CFG_W-1:0] v);
            event_count = v;
        endfunction

        function int pending();
            return expected_cuts.size();
        endfunction

        function void note_cut(t_cut c);
            expected_cuts = {expected_cuts, c};
        endfunction

        function logic [MASK_W-1:0] grow(int seed, int n, bit par, logic [MASK_W-1:0] seen);
            logic [MASK_W-1:0] comp;
            bit                changed;
            bit                link;
            comp       = '0;
            comp[seed] = 1'b1;
            changed    = 1'b1;
            while (changed) begin
                changed = 1'b0;
                for (int v = 0; v < n; v++) begin
                    if (comp[v]) begin
                        for (int i = 0; i < n; i++) begin
                            if (!comp[i] && !seen[i]) begin
                                link = par ? (rel[v][i] != REL_PARALLEL)
                                           : (rel[v][i] != REL_NONE);
                                if (link) begin
                                    comp[i] = 1'b1;
                                    changed = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            return comp;
        endfunction

        function void split(bit par, logic [MASK_W-1:0] starts, logic [MASK_W-1:0] ends, int n);
            logic [MASK_W-1:0] seen;
            logic [MASK_W-1:0] comp;
            logic [MASK_W-1:0] parts[$];
            t_cut              c;
            seen = '0;
            for (int i = 0; i < n; i++) begin
                if (!seen[i]) begin
                    comp = grow(i, n, par, seen);
                    seen |= comp;
                    if ((comp & starts) == '0 || (comp & ends) == '0) begin
                        c = '{mask: '0, is_last: 1'b1, failed: 1'b1};
                        note_cut(c);
                        return;
                    end
                    parts = {parts, comp};
                end
            end
            foreach (parts[k]) begin
                c = '{mask: parts[k], is_last: (k == parts.size() - 1), failed: 1'b0};
                note_cut(c);
            end
        endfunction

        function bit apply_item(logic [KIND_W-1:0] k, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                logic [MASK_W-1:0] starts, logic [MASK_W-1:0] ends);
            int n;
            n = span();
            items_taken++;
            case (k)
                KIND_ADD: begin
                    if (a >= n || b >= n) return 1'b0;
                    if (rel[a][b] == REL_NONE) begin
                        rel[a][b] = REL_PRECEDES;
                        rel[b][a] = REL_FOLLOWS;
                    end else if (rel[a][b] == REL_FOLLOWS) begin
                        rel[a][b] = REL_PARALLEL;
                        rel[b][a] = REL_PARALLEL;
                    end
                    return 1'b1;
                end
                KIND_CONN, KIND_PAR: begin
                    queries++;
                    split(k == KIND_PAR, starts, ends, n);
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void check_cut(logic [MASK_W-1:0] mask, logic is_last, logic failed);
            t_cut want;
            results_seen++;
            if (expected_cuts.size() == 0) begin
                errors++;
                $display("%0t: unexpected result mask %h is_last %b failed %b",
                         $time, mask, is_last, failed);
                return;
            end
            want = expected_cuts.pop_front();
            if (mask !== want.mask) begin
                errors++;
                $display("%0t: component_mask expected %h actual %h", $time, want.mask, mask);
            end
            if (is_last !== want.is_last) begin
                errors++;
                $display("%0t: is_last expected %b actual %b", $time, want.is_last, is_last);
            end
            if (failed !== want.failed) begin
                errors++;
                $display("%0t: failed expected %b actual %b", $time, want.failed, failed);
            end
        endfunction

        function void final_check();
            if (expected_cuts.size() != 0) begin
                errors += expected_cuts.size();
                $display("%0t: %0d results expected but never seen", $time,
                         expected_cuts.size());
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_we     = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata  = '0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic [KIND_W-1:0] i_kind       = KIND_ADD;
    logic [IDX_W-1:0]  i_from_event = '0;
    logic [IDX_W-1:0]  i_to_event   = '0;
    logic [MASK_W-1:0] i_start_mask = '0;
    logic [MASK_W-1:0] i_end_mask   = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic [MASK_W-1:0] o_component_mask;
    logic              o_is_last;
    logic              o_failed;

    cut_tracker sb;
    bit         idle_on       = 1'b1;
    int         hold_requests = 0;
    int         holds_served  = 0;
    int         hold_left     = 0;
    int         stall_left    = 0;

    footprint_relation_cut_finder #(.MAX_EVENTS(EVENT_CAP)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_from_event     (i_from_event),
        .i_to_event       (i_to_event),
        .i_start_mask     (i_start_mask),
        .i_end_mask       (i_end_mask),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_component_mask (o_component_mask),
        .o_is_last        (o_is_last),
        .o_failed         (o_failed)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            sb.check_cut(o_component_mask, o_is_last, o_failed);
        end
        if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = int'($urandom_range(1, 6)) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] a,
                             input logic [IDX_W-1:0] b, input logic [MASK_W-1:0] starts,
                             input logic [MASK_W-1:0] ends, output bit counted);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= k;
        i_from_event <= a;
        i_to_event   <= b;
        i_start_mask <= starts;
        i_end_mask   <= ends;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        counted = sb.apply_item(k, a, b, starts, ends);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_event_count(input logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_count(v);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] count, input int target, input bit idle);
        logic [KIND_W-1:0] k;
        logic [IDX_W-1:0]  a;
        logic [IDX_W-1:0]  b;
        logic [MASK_W-1:0] starts;
        logic [MASK_W-1:0] ends;
        int                pick;
        int                n;
        int                done;
        bit                counted;
        idle_on = idle;
        set_event_count(count);
        n    = sb.span();
        done = 0;
        while (done < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) k = KIND_ADD;
            else if (pick < 80) k = KIND_CONN;
            else if (pick < 95) k = KIND_PAR;
            else k = KIND_SPARE;
            if ($urandom_range(0, 4) != 0) begin
                a = IDX_W'($urandom_range(0, n - 1));
                b = IDX_W'($urandom_range(0, n - 1));
            end else begin
                a = IDX_W'($urandom);
                b = IDX_W'($urandom);
            end
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                starts = '1;
                ends   = '1;
            end else if (pick < 8) begin
                starts = MASK_W'($urandom | $urandom);
                ends   = MASK_W'($urandom | $urandom);
            end else begin
                starts = MASK_W'($urandom & $urandom);
                ends   = MASK_W'($urandom);
            end
            send_item(k, a, b, starts, ends, counted);
            if (counted) done++;
        end
        wait_drained();
    endtask

    initial begin
        bit hit;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(KIND_CONN, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, hit);
        send_item(KIND_PAR, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, hit);
        send_item(KIND_CONN, 4'd15, 4'd15, 16'h0000, 16'h0000, hit);
        send_item(KIND_CONN, 4'd0, 4'd0, 16'hFFFF, 16'h7FFF, hit);
        send_item(KIND_SPARE, 4'd1, 4'd2, 16'hFFFF, 16'hFFFF, hit);
        send_item(KIND_ADD, 4'd0, 4'd1, 16'h0000, 16'h0000, hit);
        send_item(KIND_ADD, 4'd1, 4'd0, 16'hFFFF, 16'hFFFF, hit);
        send_item(KIND_ADD, 4'd2, 4'd3, 16'h0000, 16'h0000, hit);
        send_item(KIND_ADD, 4'd2, 4'd3, 16'h0000, 16'h0000, hit);
        send_item(KIND_ADD, 4'd3, 4'd3, 16'h0000, 16'h0000, hit);
        send_item(KIND_ADD, 4'd3, 4'd3, 16'h0000, 16'h0000, hit);
        send_item(KIND_ADD, 4'd15, 4'd14, 16'h0000, 16'h0000, hit);
        send_item(KIND_ADD, 4'd4, 4'd2, 16'h0000, 16'h0000, hit);
        send_item(KIND_CONN, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, hit);
        send_item(KIND_PAR, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, hit);
        send_item(KIND_PAR, 4'd0, 4'd0, 16'h0001, 16'hFFFF, hit);
        wait_drained();

        hold_requests++;
        send_item(KIND_CONN, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, hit);
        send_item(KIND_ADD, 4'd5, 4'd6, 16'h0000, 16'h0000, hit);
        send_item(KIND_ADD, 4'd6, 4'd5, 16'h0000, 16'h0000, hit);
        send_item(KIND_ADD, 4'd7, 4'd8, 16'h0000, 16'h0000, hit);
        send_item(KIND_PAR, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, hit);
        wait_drained();

        run_phase(5'd5, 58, 1'b1);
        run_phase(5'd1, 40, 1'b1);
        run_phase(5'd0, 30, 1'b1);
        run_phase(5'd10, 65, 1'b1);
        run_phase(5'd31, 65, 1'b1);
        run_phase(5'd17, 65, 1'b1);
        run_phase(5'd16, 65, 1'b0);

        sb.final_check();
        $display("Covered %0d accepted items, %0d of them queries, %0d results checked,",
                 sb.items_taken, sb.queries, sb.results_seen);
        $display("with event counts from zero up to the 5-bit maximum and output hold-offs.");
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> footprint_relation_cut_finder.f
+incdir+design
design/frc_pkg.sv
design/frc_ctrl.sv
design/frc_dp.sv
design/footprint_relation_cut_finder.sv
design/frc_chk.sv
sim/tb_top.sv
